// ----- sv/pca_pkg.sv -----
// Shared types, codes and the control-store program of the PWM channel allocator.
package pca_pkg;

  localparam int CHANNELS = 3;
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

  localparam logic [31:0] TOGGLE_CONFIG = 32'h0013_0003;
  localparam int PERIOD_SHIFT = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_SLOT_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_SLOT_BASE  = 1'd1;

  // Result codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
  localparam logic [1:0] ST_CONFLICT    = 2'd2;
  localparam logic [1:0] ST_NO_CHANNEL  = 2'd3;

  localparam logic [1:0] PIN_HOLD_LOW  = 2'd0;
  localparam logic [1:0] PIN_HOLD_HIGH = 2'd1;
  localparam logic [1:0] PIN_PULSE     = 2'd2;

  localparam logic [1:0] TMR_NONE  = 2'd0;
  localparam logic [1:0] TMR_START = 2'd1;
  localparam logic [1:0] TMR_STOP  = 2'd2;

  // Datapath operation of one control word
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR_IDX,
    OP_INC_IDX,
    OP_SET_LAST,
    OP_DEC_IDX,
    OP_EMIT_OK,
    OP_EMIT_UNSUP,
    OP_EMIT_CONFLICT,
    OP_EMIT_NOCH
  } op_t;

  // Branch condition of one control word
  typedef enum logic [3:0] {
    C_NEXT,
    C_JUMP,
    C_WAIT_IN,
    C_FLAG,
    C_STAT,
    C_CONFLICT,
    C_MATCH,
    C_FREE,
    C_NOT_LAST,
    C_NOT_FIRST
  } cond_t;

  typedef logic [3:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  // Program addresses
  localparam step_t S_IDLE      = 4'd0;
  localparam step_t S_CHK_FLAG  = 4'd1;
  localparam step_t S_CHK_STAT  = 4'd2;
  localparam step_t S_CONF      = 4'd3;
  localparam step_t S_CONF_NEXT = 4'd4;
  localparam step_t S_MATCH     = 4'd5;
  localparam step_t S_MATCH_NXT = 4'd6;
  localparam step_t S_FREE_INIT = 4'd7;
  localparam step_t S_FREE      = 4'd8;
  localparam step_t S_FREE_NEXT = 4'd9;
  localparam step_t S_ERR_NOCH  = 4'd10;
  localparam step_t S_APPLY     = 4'd11;
  localparam step_t S_ERR_FLAG  = 4'd12;
  localparam step_t S_ERR_CONF  = 4'd13;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    unique case (s)
      S_IDLE:      w = '{OP_NONE,          C_WAIT_IN,   S_IDLE};
      S_CHK_FLAG:  w = '{OP_NONE,          C_FLAG,      S_ERR_FLAG};
      S_CHK_STAT:  w = '{OP_CLR_IDX,       C_STAT,      S_MATCH};
      S_CONF:      w = '{OP_NONE,          C_CONFLICT,  S_ERR_CONF};
      S_CONF_NEXT: w = '{OP_INC_IDX,       C_NOT_LAST,  S_CONF};
      S_MATCH:     w = '{OP_NONE,          C_MATCH,     S_APPLY};
      S_MATCH_NXT: w = '{OP_INC_IDX,       C_NOT_LAST,  S_MATCH};
      S_FREE_INIT: w = '{OP_SET_LAST,      C_NEXT,      S_FREE};
      S_FREE:      w = '{OP_NONE,          C_FREE,      S_APPLY};
      S_FREE_NEXT: w = '{OP_DEC_IDX,       C_NOT_FIRST, S_FREE};
      S_ERR_NOCH:  w = '{OP_EMIT_NOCH,     C_JUMP,      S_IDLE};
      S_APPLY:     w = '{OP_EMIT_OK,       C_JUMP,      S_IDLE};
      S_ERR_FLAG:  w = '{OP_EMIT_UNSUP,    C_JUMP,      S_IDLE};
      S_ERR_CONF:  w = '{OP_EMIT_CONFLICT, C_JUMP,      S_IDLE};
      default:     w = '{OP_NONE,          C_JUMP,      S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- sv/pwm_channel_allocator_core.sv -----
// PWM channel allocator: microcoded request checker, channel table and result register.
//
//   channel   dir  handshake            payload
//   request   in   in_valid / in_stall  pin, period, pulse, polarity_flag
//   result    out  out_valid/ out_stall status ... event_config_word
//   config    in   cfg_write            cfg_index, cfg_data
//
// One request at a time. A request walks the table under control of the
// program in pca_pkg: conflict walk, pin-match walk, free-entry walk, each
// two control steps per entry; the input opens again in the cycle after
// the final step.
// Reset clears the channel table, shared period and slot bases at once.
// The result register holds a valid result while out_stall is high; a new
// request can be accepted and walked meanwhile, and only its final step waits
// for the result register to free up.
module pwm_channel_allocator_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [4:0]                         pin,
  input  logic [31:0]                        period,
  input  logic [31:0]                        pulse,
  input  logic                               polarity_flag,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic [1:0]                         channel,
  output logic [1:0]                         pin_action,
  output logic [15:0]                        compare_pulse,
  output logic [15:0]                        compare_period,
  output logic [1:0]                         timer_command,
  output logic [7:0]                         event_slot,
  output logic [7:0]                         link_slot,
  output logic [31:0]                        event_config_word,
  input  logic                               cfg_write,
  input  logic [pca_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                         cfg_data
);
  import pca_pkg::*;

  // Sequencer
  step_t  step;
  step_t  step_next;
  ucode_t uw;

  // Walk index over the table
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;

  // Latched request
  logic [4:0]  pin_q;
  logic [31:0] period_q;
  logic [31:0] pulse_q;
  logic        flag_q;
  logic        stat_q;  // pulse is 0% or 100%
  logic        zero_q;  // pulse is 0%

  // Channel table: pin per entry and an active bit (pulse neither 0% nor 100%)
  logic [4:0]          entry_pin [CHANNELS];
  logic [CHANNELS-1:0] act;
  logic [CHANNELS-1:0] act_other;
  logic [31:0]         shared_period;

  logic [7:0] event_slot_base;
  logic [7:0] link_slot_base;

  logic in_accept;
  logic emit;
  logic busy;
  logic hold;
  logic load;
  logic cond_true;
  logic load_stop;

  // Result staging
  logic [1:0]  res_status;
  logic [1:0]  res_action;
  logic [15:0] res_cmp_pulse;
  logic [15:0] res_cmp_period;
  logic [1:0]  res_timer;
  logic [31:0] res_cfg_word;
  logic        res_ok;
  logic [7:0]  idx8;
  logic        shift_big;
  logic [4:0]  shamt;

  assign uw        = ucode_rom(step);
  assign in_stall  = (step != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign emit = (uw.op == OP_EMIT_OK) || (uw.op == OP_EMIT_UNSUP) ||
                (uw.op == OP_EMIT_CONFLICT) || (uw.op == OP_EMIT_NOCH);
  assign busy = out_valid && out_stall;
  assign hold = emit && busy;
  assign load = emit && !busy;

  // Branch conditions; the table tests use the entry under the walk index
  always_comb begin
    unique case (uw.cond)
      C_NEXT:      cond_true = 1'b0;
      C_JUMP:      cond_true = 1'b1;
      C_WAIT_IN:   cond_true = 1'b0;
      C_FLAG:      cond_true = flag_q;
      C_STAT:      cond_true = stat_q;
      C_CONFLICT:  cond_true = (entry_pin[idx] != pin_q) && act[idx] &&
                               (period_q != shared_period);
      C_MATCH:     cond_true = (entry_pin[idx] == pin_q);
      C_FREE:      cond_true = !act[idx];
      C_NOT_LAST:  cond_true = (idx != IDX_LAST);
      C_NOT_FIRST: cond_true = (idx != '0);
      default:     cond_true = 1'b0;
    endcase
  end

  always_comb begin
    step_next = step + 4'd1;
    if (hold) begin
      step_next = step;
    end else if (uw.cond == C_WAIT_IN) begin
      step_next = in_accept ? (step + 4'd1) : step;
    end else if (cond_true) begin
      step_next = uw.target;
    end
  end

  // Downward walk stops at entry zero so the index stays inside the table
  always_comb begin
    unique case (uw.op)
      OP_CLR_IDX:  idx_next = '0;
      OP_INC_IDX:  idx_next = (idx == IDX_LAST) ? '0 : idx + 1'b1;
      OP_SET_LAST: idx_next = IDX_LAST;
      OP_DEC_IDX:  idx_next = (idx == '0) ? '0 : idx - 1'b1;
      default:     idx_next = idx;
    endcase
  end

  // Result values for the entry under the index
  always_comb begin
    act_other      = act;
    act_other[idx] = 1'b0;
    idx8           = 8'(idx);
    shift_big      = |period_q[31:PERIOD_SHIFT+5];
    shamt          = period_q[PERIOD_SHIFT+4:PERIOD_SHIFT];
    res_ok         = (uw.op == OP_EMIT_OK);
    res_action     = PIN_HOLD_LOW;
    res_cmp_pulse  = '0;
    res_cmp_period = '0;
    res_timer      = TMR_NONE;
    res_cfg_word   = '0;
    unique case (uw.op)
      OP_EMIT_UNSUP:    res_status = ST_UNSUPPORTED;
      OP_EMIT_CONFLICT: res_status = ST_CONFLICT;
      OP_EMIT_NOCH:     res_status = ST_NO_CHANNEL;
      default:          res_status = ST_OK;
    endcase
    if (res_ok) begin
      if (stat_q) begin
        // static drive: release entry, stop timer once nothing runs
        res_action = zero_q ? PIN_HOLD_LOW : PIN_HOLD_HIGH;
        res_timer  = (|act_other) ? TMR_NONE : TMR_STOP;
      end else begin
        res_action     = PIN_PULSE;
        res_cmp_pulse  = shift_big ? '0 : 16'(pulse_q >> shamt);
        res_cmp_period = shift_big ? '0 : 16'(period_q >> shamt);
        res_timer      = TMR_START;
        res_cfg_word   = TOGGLE_CONFIG | (32'(pin_q) << 8);
      end
    end
  end

  assign load_stop = load && res_ok && (res_timer == TMR_STOP);

  // Sequencer and table state
  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= S_IDLE;
      idx           <= '0;
      act           <= '0;
      shared_period <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        entry_pin[i] <= '0;
      end
    end else begin
      step <= step_next;
      if (!hold) begin
        idx <= idx_next;
      end
      if (load && res_ok) begin
        if (stat_q) begin
          act[idx] <= 1'b0;
        end else begin
          act[idx]       <= 1'b1;
          entry_pin[idx] <= pin_q;
          shared_period  <= period_q;
        end
      end
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pin_q    <= pin;
      period_q <= period;
      pulse_q  <= pulse;
      flag_q   <= polarity_flag;
      stat_q   <= (pulse == '0) || (pulse == period);
      zero_q   <= (pulse == '0);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      event_slot_base <= '0;
      link_slot_base  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_EVENT_SLOT_BASE: event_slot_base <= cfg_data;
        REG_LINK_SLOT_BASE:  link_slot_base  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status            <= res_status;
      channel           <= res_ok ? idx8[1:0] : 2'd0;
      pin_action        <= res_action;
      compare_pulse     <= res_cmp_pulse;
      compare_period    <= res_cmp_period;
      timer_command     <= res_timer;
      event_slot        <= res_ok ? (event_slot_base + idx8) : 8'd0;
      link_slot         <= res_ok ? (link_slot_base + (idx8 << 1)) : 8'd0;
      event_config_word <= res_cfg_word;
    end
  end

`ifndef SYNTH
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= IDX_LAST)
    else $error("walk index beyond table");

  a_rose_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(load))
    else $error("result appeared without an emit step");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (channel == 2'd0 && timer_command == TMR_NONE &&
                                        event_config_word == 32'd0))
    else $error("error result carries nonzero fields");

  a_start_sets_active: assert property (@(posedge clk) disable iff (rst)
    (load && res_ok && !stat_q) |=> (act != '0))
    else $error("pulsing entry not recorded active");

  a_stop_means_idle: assert property (@(posedge clk) disable iff (rst)
    load_stop |=> (act == '0))
    else $error("timer stopped with an active entry");
`endif

endmodule
